[rtl/psgtn_pkg.sv]
// Shared types, constants and the volume table for the tone and noise generator.
// No dependencies; every other file in rtl refers to this package by scoped names.
package psgtn_pkg;

    // Channel layout
    localparam int CHANNELS     = 4;
    localparam int CNT_W        = 10;
    localparam int VOL_W        = 4;
    localparam int SHIFT_W      = 15;
    localparam int LEVEL_W      = 13;
    localparam int SAMPLE_W     = 15;
    localparam int REG_SEL_W    = 3;

    localparam logic [1:0] TONE2_CH = 2'd2;
    localparam logic [1:0] NOISE_CH = 2'd3;

    // Item commands
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    // Noise rate codes
    localparam logic [1:0] RATE_16    = 2'd0;
    localparam logic [1:0] RATE_32    = 2'd1;
    localparam logic [1:0] RATE_64    = 2'd2;
    localparam logic [1:0] RATE_TONE2 = 2'd3;

    localparam logic [CNT_W-1:0]   PERIOD_16   = 10'h010;
    localparam logic [CNT_W-1:0]   PERIOD_32   = 10'h020;
    localparam logic [CNT_W-1:0]   PERIOD_64   = 10'h040;
    localparam logic [SHIFT_W-1:0] NOISE_SEED  = 15'h4000;
    localparam logic [LEVEL_W-1:0] FULL_LEVEL  = 13'd8191;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_INVERT_LEVELS = 1'b0;

    // Per-cycle view of the channels handed to the mixer
    typedef struct packed {
        logic [CHANNELS-1:0]            out_bit;
        logic [CHANNELS-1:0][VOL_W-1:0] volume;
    } psgtn_mix_t;

    // Attenuation table, 2 dB a step, silence at the last entry
    function automatic logic [LEVEL_W-1:0] level_of(input logic [VOL_W-1:0] idx,
                                                     input logic           invert);
        logic [LEVEL_W-1:0] v;
        begin
            unique case (idx)
                4'd0:    v = 13'd8191;
                4'd1:    v = 13'd6506;
                4'd2:    v = 13'd5168;
                4'd3:    v = 13'd4105;
                4'd4:    v = 13'd3261;
                4'd5:    v = 13'd2590;
                4'd6:    v = 13'd2057;
                4'd7:    v = 13'd1634;
                4'd8:    v = 13'd1298;
                4'd9:    v = 13'd1031;
                4'd10:   v = 13'd819;
                4'd11:   v = 13'd651;
                4'd12:   v = 13'd517;
                4'd13:   v = 13'd411;
                4'd14:   v = 13'd326;
                default: v = 13'd0;
            endcase
            level_of = invert ? (FULL_LEVEL - v) : v;
        end
    endfunction

    // Noise reload period for a rate code
    function automatic logic [CNT_W-1:0] noise_period(input logic [1:0]       rate,
                                                      input logic [CNT_W-1:0] tone2);
        begin
            unique case (rate)
                RATE_16:    noise_period = PERIOD_16;
                RATE_32:    noise_period = PERIOD_32;
                RATE_64:    noise_period = PERIOD_64;
                RATE_TONE2: noise_period = tone2;
            endcase
        end
    endfunction

endpackage

[rtl/psgtn_gen.sv]
// Generator state: register write decoding, tone/noise counters and the noise shifter.
// Depends on psgtn_pkg; feeds psgtn_mixer with the updated channel bits and volumes.
module psgtn_gen (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          fire,
    input  logic                          command,
    input  logic [7:0]                    write_data,
    output psgtn_pkg::psgtn_mix_t         mix
);

    localparam int N  = psgtn_pkg::CHANNELS;
    localparam int CW = psgtn_pkg::CNT_W;
    localparam int VW = psgtn_pkg::VOL_W;
    localparam int SW = psgtn_pkg::SHIFT_W;

    logic [N-1:0][CW-1:0] counter_reg, counter_next;
    logic [N-1:0]         ff_reg, ff_next;
    logic [N-1:0][VW-1:0] vol_reg, vol_next;
    logic [N-1:0][CW-1:0] period_reg, period_next;
    logic [SW-1:0]        shift_reg, shift_next;
    logic                 mode_reg, mode_next;
    logic [1:0]           rate_reg, rate_next;
    logic [psgtn_pkg::REG_SEL_W-1:0] latched_reg, latched_next;

    logic [psgtn_pkg::REG_SEL_W-1:0] sel;
    logic [1:0]           ch;
    logic [CW-1:0]        wr_period;
    logic [N-1:0][CW-1:0] dec;
    logic [N-1:0]         expired;
    logic [SW-1:0]        shifted;

    // Hold the generator state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            counter_reg <= '0;
            ff_reg      <= '0;
            vol_reg     <= '0;
            period_reg  <= '0;
            period_reg[psgtn_pkg::NOISE_CH] <= psgtn_pkg::PERIOD_64;
            shift_reg   <= '0;
            mode_reg    <= 1'b0;
            rate_reg    <= psgtn_pkg::RATE_64;
            latched_reg <= '0;
        end else begin
            counter_reg <= counter_next;
            ff_reg      <= ff_next;
            vol_reg     <= vol_next;
            period_reg  <= period_next;
            shift_reg   <= shift_next;
            mode_reg    <= mode_next;
            rate_reg    <= rate_next;
            latched_reg <= latched_next;
        end
    end

    // Decode a write or advance all counters by one tick
    always_comb begin
        counter_next = counter_reg;
        ff_next      = ff_reg;
        vol_next     = vol_reg;
        period_next  = period_reg;
        shift_next   = shift_reg;
        mode_next    = mode_reg;
        rate_next    = rate_reg;
        latched_next = latched_reg;
        sel          = write_data[7] ? write_data[6:4] : latched_reg;
        ch           = sel[2:1];
        wr_period    = period_reg[ch];
        shifted      = shift_reg >> 1;
        for (int c = 0; c < N; c++) begin
            dec[c]     = counter_reg[c] - CW'(1);
            expired[c] = (dec[c] == '0);
        end
        if (fire) begin
            unique case (command)
                psgtn_pkg::CMD_WRITE: begin
                    latched_next = sel;
                    if (sel[0]) begin
                        vol_next[ch] = write_data[VW-1:0];
                    end else if (ch == psgtn_pkg::NOISE_CH) begin
                        // Noise control: rate, mode, reseed the shifter
                        rate_next  = write_data[1:0];
                        mode_next  = write_data[2];
                        shift_next = psgtn_pkg::NOISE_SEED;
                        wr_period  = psgtn_pkg::noise_period(write_data[1:0],
                                                             period_reg[psgtn_pkg::TONE2_CH]);
                        period_next[psgtn_pkg::NOISE_CH] = wr_period;
                    end else begin
                        if (write_data[7]) begin
                            wr_period = {period_reg[ch][CW-1:4], write_data[3:0]};
                        end else begin
                            wr_period = {write_data[5:0], period_reg[ch][3:0]};
                        end
                        period_next[ch] = wr_period;
                        // Noise tracking tone 2 follows its period
                        if (ch == psgtn_pkg::TONE2_CH && rate_reg == psgtn_pkg::RATE_TONE2) begin
                            period_next[psgtn_pkg::NOISE_CH] = wr_period;
                        end
                    end
                end
                psgtn_pkg::CMD_TICK: begin
                    for (int c = 0; c < N; c++) begin
                        if (expired[c]) begin
                            counter_next[c] = period_reg[c];
                            ff_next[c]      = ~ff_reg[c];
                        end else begin
                            counter_next[c] = dec[c];
                        end
                    end
                    // Step the shifter on a rising noise toggle
                    if (expired[psgtn_pkg::NOISE_CH] && !ff_reg[psgtn_pkg::NOISE_CH]) begin
                        if (mode_reg) begin
                            shift_next = {shift_reg[0] ^ shift_reg[1], shift_reg[SW-1:1]};
                        end else if (shifted == '0) begin
                            shift_next = psgtn_pkg::NOISE_SEED;
                        end else begin
                            shift_next = shifted;
                        end
                    end
                end
            endcase
        end
    end

    // Channel view after this item
    assign mix.out_bit = {shift_next[0], ff_next[N-2:0]};
    assign mix.volume  = vol_next;

endmodule

[rtl/psgtn_mixer.sv]
// Volume table lookup, four-way sum and the result register.
// Depends on psgtn_pkg; takes the channel view from psgtn_gen.
module psgtn_mixer (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                load,
    input  logic                                take,
    input  logic                                invert_levels,
    input  psgtn_pkg::psgtn_mix_t               mix,
    output logic                                m_valid,
    output logic [psgtn_pkg::SAMPLE_W-1:0]      m_sample
);

    localparam int N  = psgtn_pkg::CHANNELS;
    localparam int SW = psgtn_pkg::SAMPLE_W;

    logic              valid_reg, valid_next;
    logic [SW-1:0]     sample_reg;
    logic [N-1:0][psgtn_pkg::LEVEL_W-1:0] level;
    logic [SW-1:0]     sum;

    // Look up each channel, forcing the last table entry (silence unless inverted) when its output bit is low
    always_comb begin
        for (int c = 0; c < N; c++) begin
            level[c] = psgtn_pkg::level_of(mix.out_bit[c] ? mix.volume[c]
                                                          : psgtn_pkg::VOL_W'(15),
                                           invert_levels);
        end
        sum = SW'(level[0]) + SW'(level[1]) + SW'(level[2]) + SW'(level[3]);
    end

    // Hold the word until taken
    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            sample_reg <= sum;
        end
    end

    assign m_valid  = valid_reg;
    assign m_sample = sample_reg;

endmodule

[rtl/psg_tone_noise_generator_core.sv]
// Three-tone, one-noise sound generator: one word per cycle, writes or ticks, while no tick is stalled.
// A tick word is held in the input register, then its sample is loaded into the result register and shown on m_sample.
// The output register frees a slot while m_ready is high; a tick word waits in the input register until then.
// Writes give no sample. Reset (aresetn low, synchronous) restores all channel state
// and clears the level inversion bit; the input and result stages come up empty.
module psg_tone_noise_generator_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input words
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_command,
    input  logic [7:0]                          s_write_data,
    // samples
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [psgtn_pkg::SAMPLE_W-1:0]      m_sample,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [psgtn_pkg::PADDR_W-1:0]       paddr,
    input  logic [psgtn_pkg::PDATA_W-1:0]       pwdata,
    output logic [psgtn_pkg::PDATA_W-1:0]       prdata,
    output logic                                pready
);

    logic       in_valid_reg, in_valid_next;
    logic       in_cmd_reg;
    logic [7:0] in_data_reg;
    logic       silence_reg;
    logic       out_free;
    logic       fire;
    logic       accept;
    psgtn_pkg::psgtn_mix_t mix;

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            silence_reg <= 1'b0;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == psgtn_pkg::REG_INVERT_LEVELS) begin
            silence_reg <= pwdata[0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == psgtn_pkg::REG_INVERT_LEVELS)
                    ? {{(psgtn_pkg::PDATA_W-1){1'b0}}, silence_reg} : '0;

    // Process the held word: a write always, a tick only when its result has somewhere to go
    assign out_free = !m_valid || m_ready;
    assign fire     = in_valid_reg && (in_cmd_reg == psgtn_pkg::CMD_WRITE || out_free);
    assign s_ready  = !in_valid_reg || fire;
    assign accept   = s_valid && s_ready;

    // Input register
    always_comb begin
        in_valid_next = in_valid_reg;
        if (accept) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            in_cmd_reg  <= s_command;
            in_data_reg <= s_write_data;
        end
    end

    psgtn_gen u_gen (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fire       (fire),
        .command    (in_cmd_reg),
        .write_data (in_data_reg),
        .mix        (mix)
    );

    psgtn_mixer u_mixer (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (fire && in_cmd_reg == psgtn_pkg::CMD_TICK),
        .take          (m_ready),
        .invert_levels (silence_reg),
        .mix           (mix),
        .m_valid       (m_valid),
        .m_sample      (m_sample)
    );

endmodule

[rtl/psgtn_checker.sv]
// Port-level checks for the tone and noise generator core.
// Depends on psg_tone_noise_generator_core; attached by the bind below.
module psgtn_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic [psgtn_pkg::SAMPLE_W-1:0]      m_sample,
    input logic                                psel,
    input logic                                penable,
    input logic                                pwrite,
    input logic [psgtn_pkg::PADDR_W-1:0]       paddr,
    input logic [psgtn_pkg::PDATA_W-1:0]       pwdata,
    input logic [psgtn_pkg::PDATA_W-1:0]       prdata
);

    // No sample is offered straight after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("sample offered after reset");

    // A stalled sample holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_sample))
        else $error("stalled sample changed");

    // Four levels of at most 8191 each
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_sample <= 15'd32764)
        else $error("sample above full scale");

    // A register read right after a write returns the written bit
    a_readback: assert property (@(posedge aclk) disable iff (!aresetn)
        (psel && penable && pwrite && paddr[2] == psgtn_pkg::REG_INVERT_LEVELS)
        ##1 (psel && penable && !pwrite && paddr[2] == psgtn_pkg::REG_INVERT_LEVELS)
        |-> prdata[0] == $past(pwdata[0]))
        else $error("register readback mismatch");

endmodule

bind psg_tone_noise_generator_core psgtn_checker u_psgtn_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_sample (m_sample),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata)
);
